/* sv/rts_pkg.sv */
// ----------------------------------------------------------------------------
// rts_pkg
// Shared types and codes for the radio transmit/receive supervisor.
// ----------------------------------------------------------------------------
package rts_pkg;

  // Command codes carried on the input tuser
  typedef enum logic [1:0] {
    CMD_TX   = 2'd0,
    CMD_RX   = 2'd1,
    CMD_TICK = 2'd2,
    CMD_IRQ  = 2'd3
  } cmd_t;

  // Operation in progress
  typedef enum logic [1:0] {
    OP_IDLE = 2'd0,
    OP_TX   = 2'd1,
    OP_RX   = 2'd2
  } op_t;

  // Request status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ERROR   = 2'd1,
    ST_BUSY    = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  // Radio flag bit positions
  localparam int unsigned FLAG_TX_DONE_BIT = 3;
  localparam int unsigned FLAG_CRC_ERR_BIT = 5;
  localparam int unsigned FLAG_RX_DONE_BIT = 6;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 16;

  // One input request
  typedef struct packed {
    cmd_t        command;
    logic [7:0]  payload_length;
    logic [7:0]  rx_max_len;
    logic [31:0] timeout_limit;
    logic [7:0]  radio_flags;
    logic [7:0]  received_bytes;
    logic        bus_error;
  } item_t;

  // One result
  typedef struct packed {
    status_t    status;
    op_t        op_state;
    logic       done_res;
    logic [7:0] accepted_len;
    logic       read_payload;
  } result_t;

endpackage

/* sv/radio_txrx_supervisor_core.sv */
// ----------------------------------------------------------------------------
// radio_txrx_supervisor_core
// Supervisor for one non-blocking radio transmit or receive operation.
// ----------------------------------------------------------------------------
// Takes one request per clock with no bubbles while the result side does not
// stall; each request yields exactly one result (input register, decision
// logic, result register). The rate is set by the state update in the engine,
// which reads and writes the supervisor state once per request. Back pressure
// on the result side holds the input side only when both registers are full.
module radio_txrx_supervisor_core #(
  parameter int unsigned TIMER_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [7:0] payload_length, [15:8] rx_max_len, [47:16] timeout_limit,
  // [55:48] radio_flags, [63:56] received_bytes, [64] bus_error, rest zero
  input  logic [rts_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [1:0] command
  input  logic [1:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [1:0] status, [3:2] op_state, [4] done_res, [12:5] accepted_len,
  // [13] read_payload, rest zero
  output logic [rts_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  logic             item_valid;
  logic             res_ready;
  logic             advance;
  rts_pkg::item_t   item;
  rts_pkg::result_t res;

  assign advance = item_valid && res_ready;

  rts_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  rts_engine #(
    .TIMER_BITS (TIMER_BITS)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .res     (res)
  );

  rts_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (item_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* sv/rts_in_stage.sv */
// ----------------------------------------------------------------------------
// rts_in_stage
// Input register: unpacks and holds one request until the engine takes it.
// ----------------------------------------------------------------------------
module rts_in_stage (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [rts_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  logic [1:0]                           in_tuser,
  input  logic                                 take,
  output logic                                 item_valid,
  output rts_pkg::item_t                       item
);

  logic           valid_r;
  logic           valid_nxt;
  rts_pkg::item_t item_r;

  // Free when empty or when the held request moves on this cycle
  assign in_tready = !valid_r || take;
  assign valid_nxt = in_tvalid || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_tready ? in_tvalid : valid_nxt;
    end
  end

  // Payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.command        <= rts_pkg::cmd_t'(in_tuser);
      item_r.payload_length <= in_tdata[7:0];
      item_r.rx_max_len     <= in_tdata[15:8];
      item_r.timeout_limit  <= in_tdata[47:16];
      item_r.radio_flags    <= in_tdata[55:48];
      item_r.received_bytes <= in_tdata[63:56];
      item_r.bus_error      <= in_tdata[64];
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

/* sv/rts_engine.sv */
// ----------------------------------------------------------------------------
// rts_engine
// Supervisor state and the single-pass decision logic for one request.
// ----------------------------------------------------------------------------
module rts_engine #(
  parameter int unsigned TIMER_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  rts_pkg::item_t    item,
  output rts_pkg::result_t  res
);

  rts_pkg::op_t          operation_r, operation_nxt;
  rts_pkg::status_t      last_status_r, last_status_nxt;
  logic [TIMER_BITS-1:0] elapsed_r, elapsed_nxt;
  logic [TIMER_BITS-1:0] limit_r, limit_nxt;
  logic [7:0]            max_accept_r, max_accept_nxt;
  logic [7:0]            acc_len_r, acc_len_nxt;

  rts_pkg::status_t      st;
  logic                  done;
  logic                  rd;
  logic [7:0]            start_len;
  rts_pkg::op_t          start_kind;
  logic [TIMER_BITS-1:0] elapsed_inc;
  logic                  rx_good;

  // Saturating millisecond count
  assign elapsed_inc = (elapsed_r == {TIMER_BITS{1'b1}}) ? elapsed_r
                                                         : elapsed_r + TIMER_BITS'(1);

  assign start_kind = (item.command == rts_pkg::CMD_RX) ? rts_pkg::OP_RX : rts_pkg::OP_TX;
  assign start_len  = (item.command == rts_pkg::CMD_RX) ? item.rx_max_len
                                                        : item.payload_length;

  assign rx_good = item.radio_flags[rts_pkg::FLAG_RX_DONE_BIT]
                && !item.radio_flags[rts_pkg::FLAG_CRC_ERR_BIT]
                && (item.received_bytes <= max_accept_r);

  // Decision logic
  always_comb begin
    operation_nxt   = operation_r;
    last_status_nxt = last_status_r;
    elapsed_nxt     = elapsed_r;
    limit_nxt       = limit_r;
    max_accept_nxt  = max_accept_r;
    acc_len_nxt     = acc_len_r;
    st              = last_status_r;
    done            = 1'b0;
    rd              = 1'b0;
    case (item.command)
      rts_pkg::CMD_TX, rts_pkg::CMD_RX: begin
        if (start_len == 8'd0) begin
          st = rts_pkg::ST_ERROR;
        end else if (operation_r != rts_pkg::OP_IDLE) begin
          st = rts_pkg::ST_BUSY;
        end else begin
          if (start_kind == rts_pkg::OP_RX) begin
            acc_len_nxt = 8'd0;
          end
          if (item.bus_error) begin
            last_status_nxt = rts_pkg::ST_ERROR;
            st              = rts_pkg::ST_ERROR;
          end else begin
            elapsed_nxt     = '0;
            limit_nxt       = item.timeout_limit[TIMER_BITS-1:0];
            last_status_nxt = rts_pkg::ST_BUSY;
            operation_nxt   = start_kind;
            if (start_kind == rts_pkg::OP_RX) begin
              max_accept_nxt = start_len;
            end
            st = rts_pkg::ST_OK;
          end
        end
      end
      rts_pkg::CMD_TICK: begin
        if (operation_r != rts_pkg::OP_IDLE) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= limit_r) begin
            st   = rts_pkg::ST_TIMEOUT;
            done = 1'b1;
          end else begin
            st = rts_pkg::ST_BUSY;
          end
        end
      end
      default: begin
        // Radio done interrupt
        if (operation_r != rts_pkg::OP_IDLE) begin
          done = 1'b1;
          if (item.bus_error) begin
            st = rts_pkg::ST_ERROR;
          end else if (operation_r == rts_pkg::OP_TX) begin
            st = item.radio_flags[rts_pkg::FLAG_TX_DONE_BIT] ? rts_pkg::ST_OK
                                                             : rts_pkg::ST_ERROR;
          end else if (!rx_good) begin
            st = rts_pkg::ST_ERROR;
          end else begin
            acc_len_nxt = item.received_bytes;
            rd          = 1'b1;
            st          = rts_pkg::ST_OK;
          end
        end
      end
    endcase
    // Common finish
    if (done) begin
      operation_nxt   = rts_pkg::OP_IDLE;
      last_status_nxt = st;
      max_accept_nxt  = 8'd0;
    end
  end

  assign res.status       = st;
  assign res.op_state     = operation_nxt;
  assign res.done_res     = done;
  assign res.accepted_len = acc_len_nxt;
  assign res.read_payload = rd;

  // State update on each processed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      operation_r   <= rts_pkg::OP_IDLE;
      last_status_r <= rts_pkg::ST_OK;
      elapsed_r     <= '0;
      limit_r       <= '0;
      max_accept_r  <= 8'd0;
      acc_len_r     <= 8'd0;
    end else if (advance) begin
      operation_r   <= operation_nxt;
      last_status_r <= last_status_nxt;
      elapsed_r     <= elapsed_nxt;
      limit_r       <= limit_nxt;
      max_accept_r  <= max_accept_nxt;
      acc_len_r     <= acc_len_nxt;
    end
  end

`ifndef SYNTHESIS
  // Receive limit is only held while a receive runs
  a_max_idle: assert property (@(posedge clk) disable iff (!rst_n)
    operation_r != rts_pkg::OP_RX |-> max_accept_r == 8'd0)
    else $error("max_accept set outside a receive");

  // A running operation has not yet reached its limit, or has no elapsed time yet
  a_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
    operation_r != rts_pkg::OP_IDLE |-> (elapsed_r < limit_r || elapsed_r == '0))
    else $error("elapsed time past the limit while active");

  // Nothing finishes when nothing runs
  a_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
    advance && operation_r == rts_pkg::OP_IDLE |-> !res.done_res)
    else $error("finish reported while idle");

  // Payload read only on a clean receive finish
  a_read: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.read_payload |->
      res.done_res && res.status == rts_pkg::ST_OK && operation_r == rts_pkg::OP_RX)
    else $error("payload read on a bad finish");

  // Finish is visible in state on the next edge
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.done_res |=> operation_r == rts_pkg::OP_IDLE)
    else $error("operation still active after finish");
`endif

endmodule

/* sv/rts_out_stage.sv */
// ----------------------------------------------------------------------------
// rts_out_stage
// Result register: holds one packed result until the sink takes it.
// ----------------------------------------------------------------------------
module rts_out_stage (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              res_valid,
  output logic                              res_ready,
  input  rts_pkg::result_t                  res,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rts_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  logic                            valid_r;
  logic [rts_pkg::OUT_TDATA_W-1:0] data_r;

  assign res_ready = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  // Pack fields from the lowest bit up, zero fill to whole bytes
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      data_r <= {2'b00, res.read_payload, res.accepted_len, res.done_res,
                 2'(res.op_state), 2'(res.status)};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule
